>>> rtl/core/sts_pkg.sv
// shared types, constants and the sub-triangle corner table of the sphere subdivider
`timescale 1ns / 1ps

package sts_pkg;

  // field widths
  localparam int COORD_W = 16;
  localparam int IDX_W   = 16;
  // cross product components and normalizer input
  localparam int WIDE_W  = 34;
  // residual width of the square root recurrence
  localparam int REM_W   = 66;
  // magnitudes are shrunk below 2^MAG_LIMIT_W before squaring
  localparam int MAG_LIMIT_W = 16;
  // fixed point scale of the root test (2^30)
  localparam int SCALE_SHIFT = 30;
  // root digits, one per cycle
  localparam int ROOT_STEPS = 16;

  // top level defaults
  localparam int INDEX_BITS_DEF  = 16;
  localparam int QUEUE_DEPTH_DEF = 2;
  localparam int OUT_DEPTH_DEF   = 4;

  // record kinds
  localparam logic KIND_VERT = 1'b0;
  localparam logic KIND_TRI  = 1'b1;

  // register decode on paddr[2]
  localparam logic REG_BASE_COUNT = 1'b0;

  typedef logic signed [COORD_W-1:0] coord_t;
  typedef logic signed [WIDE_W-1:0]  wide_t;
  typedef logic [2:0][COORD_W-1:0]   vec3_t;

  // one accepted triangle with its assigned vertex indices
  typedef struct packed {
    vec3_t [2:0]             pos;
    logic [2:0][IDX_W-1:0]   idx;
    logic [2:0][IDX_W-1:0]   nidx;
    logic                    ovf;
  } tri_t;

  // one result record
  typedef struct packed {
    logic                    kind;
    vec3_t                   pos;
    logic [2:0][IDX_W-1:0]   idx;
    vec3_t                   nrm;
    logic                    ovf;
    logic                    last;
  } rec_t;

  // point number (a, b, c, ab, bc, ca) of corner crn of sub-triangle sub
  function automatic logic [2:0] tri_corner(input logic [1:0] sub, input logic [1:0] crn);
    logic [8:0] row;
    logic [2:0] pt;
    case (sub)
      2'd0:    row = {3'd5, 3'd3, 3'd0};
      2'd1:    row = {3'd4, 3'd1, 3'd3};
      2'd2:    row = {3'd2, 3'd4, 3'd5};
      default: row = {3'd5, 3'd4, 3'd3};
    endcase
    case (crn)
      2'd0:    pt = row[2:0];
      2'd1:    pt = row[5:3];
      default: pt = row[8:6];
    endcase
    return pt;
  endfunction

endpackage

>>> rtl/core/sts_fifo.sv
// small register queue used between front and back and for result records
`timescale 1ns / 1ps

module sts_fifo #(
  parameter int Width = $bits(sts_pkg::rec_t),
  parameter int Depth = sts_pkg::OUT_DEPTH_DEF
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             push_i,
  input  logic [Width-1:0] data_i,
  output logic             full_o,
  input  logic             pop_i,
  output logic [Width-1:0] data_o,
  output logic             empty_o
);

  localparam int AW = (Depth > 1) ? $clog2(Depth) : 1;

  logic [Width-1:0] mem_q [Depth];
  logic [AW-1:0]    wptr_q, rptr_q;
  logic [AW:0]      count_q;
  logic             wr, rd;

  assign full_o  = (count_q == (AW+1)'(Depth));
  assign empty_o = (count_q == '0);
  assign wr      = push_i & ~full_o;
  assign rd      = pop_i & ~empty_o;
  assign data_o  = mem_q[rptr_q];

  // pointers and fill count
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wptr_q  <= '0;
      rptr_q  <= '0;
      count_q <= '0;
    end else begin
      if (wr) begin
        wptr_q <= (wptr_q == AW'(Depth - 1)) ? '0 : wptr_q + AW'(1);
      end
      if (rd) begin
        rptr_q <= (rptr_q == AW'(Depth - 1)) ? '0 : rptr_q + AW'(1);
      end
      if (wr && !rd) begin
        count_q <= count_q + (AW+1)'(1);
      end else if (rd && !wr) begin
        count_q <= count_q - (AW+1)'(1);
      end
    end
  end

  // storage
  always_ff @(posedge clk_i) begin
    if (wr) begin
      mem_q[wptr_q] <= data_i;
    end
  end

endmodule

>>> rtl/core/sts_front.sv
// front part: accepts triangles, assigns new vertex indices and tracks counter wrap
`timescale 1ns / 1ps

module sts_front #(
  parameter int IndexBits = sts_pkg::INDEX_BITS_DEF
) (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            cfg_load_i,
  input  logic [15:0]                     cfg_value_i,
  input  logic                            push_i,
  input  logic                            full_i,
  input  sts_pkg::vec3_t [2:0]            pos_i,
  input  logic [2:0][sts_pkg::IDX_W-1:0]  idx_i,
  output logic                            wr_o,
  output sts_pkg::tri_t                   entry_o
);

  logic [IndexBits-1:0] cnt_q, cnt_d;
  logic                 ovf_q, ovf_d;
  logic [IndexBits-1:0] n1, n2, n3;
  logic                 wrap;
  logic                 accept;

  // three counter steps per triangle
  assign n1     = cnt_q + IndexBits'(1);
  assign n2     = cnt_q + IndexBits'(2);
  assign n3     = cnt_q + IndexBits'(3);
  assign wrap   = (n1 == '0) | (n2 == '0) | (n3 == '0);
  assign accept = push_i & ~full_i;
  assign wr_o   = accept;

  // counter update on register write or transaction
  always_comb begin
    cnt_d = cnt_q;
    ovf_d = ovf_q;
    if (cfg_load_i) begin
      cnt_d = IndexBits'({16'd0, cfg_value_i});
      ovf_d = 1'b0;
    end else if (accept) begin
      cnt_d = n3;
      ovf_d = ovf_q | wrap;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q <= '0;
      ovf_q <= 1'b0;
    end else begin
      cnt_q <= cnt_d;
      ovf_q <= ovf_d;
    end
  end

  // queue entry
  always_comb begin
    entry_o.pos     = pos_i;
    entry_o.idx     = idx_i;
    entry_o.nidx[0] = sts_pkg::IDX_W'(cnt_q);
    entry_o.nidx[1] = sts_pkg::IDX_W'(n1);
    entry_o.nidx[2] = sts_pkg::IDX_W'(n2);
    entry_o.ovf     = ovf_q | wrap;
  end

endmodule

>>> rtl/core/sts_norm.sv
// shared normalizer: shrink, sum of squares, then a digit-per-cycle root test in three lanes
`timescale 1ns / 1ps

module sts_norm (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             start_i,
  input  sts_pkg::wide_t   vec_i [3],
  output logic             done_o,
  output sts_pkg::coord_t  res_o [3]
);

  localparam int MagW = sts_pkg::WIDE_W;
  localparam int RemW = sts_pkg::REM_W;
  localparam int LimW = sts_pkg::MAG_LIMIT_W;

  localparam logic [2:0] N_IDLE   = 3'd0;
  localparam logic [2:0] N_SHRINK = 3'd1;
  localparam logic [2:0] N_SQ     = 3'd2;
  localparam logic [2:0] N_INIT   = 3'd3;
  localparam logic [2:0] N_ITER   = 3'd4;
  localparam logic [2:0] N_DONE   = 3'd5;

  logic [2:0]        state_q, state_d;
  logic [3:0]        k_q, k_d;
  logic [1:0]        sel_q, sel_d;
  logic [MagW-1:0]   mag_q [3];
  logic              neg_q [3];
  logic [2*LimW-1:0] sq_q  [3];
  logic [MagW-1:0]   s_q;
  logic [RemW-1:0]   rem_q [3];
  logic [RemW-1:0]   x_q   [3];
  logic [RemW-1:0]   y_q;
  logic [15:0]       t_q   [3];
  logic              big;
  logic [2*LimW-1:0] sq_prod;
  logic [RemW-1:0]   trial [3];
  logic              take  [3];
  logic [16:0]       q17   [3];

  // any magnitude still too large
  assign big = (|mag_q[0][MagW-1:LimW]) | (|mag_q[1][MagW-1:LimW]) |
               (|mag_q[2][MagW-1:LimW]);

  // one squaring per cycle
  assign sq_prod = mag_q[sel_q][LimW-1:0] * mag_q[sel_q][LimW-1:0];

  // root digit test per lane
  always_comb begin
    for (int i = 0; i < 3; i++) begin
      trial[i] = x_q[i] + y_q;
      take[i]  = (rem_q[i] >= trial[i]);
    end
  end

  // sequencer
  always_comb begin
    state_d = state_q;
    k_d     = k_q;
    sel_d   = sel_q;
    unique case (state_q)
      N_IDLE: begin
        if (start_i) state_d = N_SHRINK;
      end
      N_SHRINK: begin
        if (!big) begin
          state_d = N_SQ;
          sel_d   = 2'd0;
        end
      end
      N_SQ: begin
        sel_d = sel_q + 2'd1;
        if (sel_q == 2'd2) state_d = N_INIT;
      end
      N_INIT: begin
        state_d = N_ITER;
        k_d     = 4'(sts_pkg::ROOT_STEPS - 1);
      end
      N_ITER: begin
        k_d = k_q - 4'd1;
        if (k_q == 4'd0) state_d = N_DONE;
      end
      N_DONE: begin
        state_d = N_IDLE;
      end
      default: state_d = N_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= N_IDLE;
      k_q     <= '0;
      sel_q   <= '0;
    end else begin
      state_q <= state_d;
      k_q     <= k_d;
      sel_q   <= sel_d;
    end
  end

  // datapath
  always_ff @(posedge clk_i) begin
    if (state_q == N_IDLE && start_i) begin
      for (int i = 0; i < 3; i++) begin
        neg_q[i] <= vec_i[i][MagW-1];
        mag_q[i] <= vec_i[i][MagW-1] ? MagW'(-vec_i[i]) : MagW'(vec_i[i]);
      end
    end
    if (state_q == N_SHRINK && big) begin
      for (int i = 0; i < 3; i++) begin
        mag_q[i] <= mag_q[i] >> 1;
      end
    end
    if (state_q == N_SQ) begin
      sq_q[sel_q] <= sq_prod;
      s_q         <= ((sel_q == 2'd0) ? '0 : s_q) + MagW'(sq_prod);
    end
    if (state_q == N_INIT) begin
      for (int i = 0; i < 3; i++) begin
        rem_q[i] <= RemW'({sq_q[i], {sts_pkg::SCALE_SHIFT{1'b0}}});
        x_q[i]   <= '0;
        t_q[i]   <= '0;
      end
      y_q <= RemW'({s_q, {sts_pkg::SCALE_SHIFT{1'b0}}});
    end
    if (state_q == N_ITER) begin
      for (int i = 0; i < 3; i++) begin
        if (take[i]) begin
          rem_q[i]     <= rem_q[i] - trial[i];
          x_q[i]       <= (x_q[i] + (y_q << 1)) >> 1;
          t_q[i][k_q]  <= 1'b1;
        end else begin
          x_q[i] <= x_q[i] >> 1;
        end
      end
      y_q <= y_q >> 2;
    end
  end

  // round half up and restore sign; zero vector gives zero
  always_comb begin
    for (int i = 0; i < 3; i++) begin
      q17[i] = {1'b0, t_q[i]} + 17'd1;
      if (s_q == '0) begin
        res_o[i] = '0;
      end else if (neg_q[i]) begin
        res_o[i] = -$signed({1'b0, q17[i][15:1]});
      end else begin
        res_o[i] = $signed({1'b0, q17[i][15:1]});
      end
    end
  end

  assign done_o = (state_q == N_DONE);

endmodule

>>> rtl/core/sts_back.sv
// back part: midpoints, cross products and record assembly around the shared normalizer
`timescale 1ns / 1ps

module sts_back (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           q_empty_i,
  input  sts_pkg::tri_t  q_entry_i,
  output logic           q_pop_o,
  input  logic           rec_full_i,
  output logic           rec_push_o,
  output sts_pkg::rec_t  rec_o
);

  localparam int WW = sts_pkg::WIDE_W;

  localparam logic [3:0] B_IDLE   = 4'd0;
  localparam logic [3:0] B_VSTART = 4'd1;
  localparam logic [3:0] B_VWAIT  = 4'd2;
  localparam logic [3:0] B_VEMIT  = 4'd3;
  localparam logic [3:0] B_EDGE   = 4'd4;
  localparam logic [3:0] B_MUL    = 4'd5;
  localparam logic [3:0] B_TSTART = 4'd6;
  localparam logic [3:0] B_TWAIT  = 4'd7;
  localparam logic [3:0] B_TEMIT  = 4'd8;

  logic [3:0]             state_q, state_d;
  logic [1:0]             k_q, k_d;
  logic [2:0]             m_q, m_d;
  sts_pkg::vec3_t         mid_q [3];
  sts_pkg::vec3_t         nrm_q;
  logic signed [16:0]     e1_q [3];
  logic signed [16:0]     e2_q [3];
  sts_pkg::wide_t         prod_q;
  sts_pkg::wide_t         c_q [3];

  sts_pkg::vec3_t         pts [6];
  logic [sts_pkg::IDX_W-1:0] ids [6];
  logic [1:0]             kn;
  logic signed [16:0]     vsum [3];
  sts_pkg::vec3_t         p0, p1, p2;
  logic [1:0]             comp, ia, ib;
  logic signed [16:0]     opa, opb;
  sts_pkg::wide_t         prod_d;
  logic [2:0]             pm;
  logic                   start;
  logic                   done;
  sts_pkg::wide_t         nvec [3];
  sts_pkg::coord_t        nres [3];
  logic                   emit_ok;

  function automatic logic [1:0] nxt(input logic [1:0] i);
    logic [1:0] r;
    case (i)
      2'd0:    r = 2'd1;
      2'd1:    r = 2'd2;
      default: r = 2'd0;
    endcase
    return r;
  endfunction

  function automatic logic [1:0] prv(input logic [1:0] i);
    logic [1:0] r;
    case (i)
      2'd0:    r = 2'd2;
      2'd1:    r = 2'd0;
      default: r = 2'd1;
    endcase
    return r;
  endfunction

  // points a, b, c, ab, bc, ca and their indices
  always_comb begin
    for (int v = 0; v < 3; v++) begin
      pts[v]     = q_entry_i.pos[v];
      pts[v + 3] = mid_q[v];
      ids[v]     = q_entry_i.idx[v];
      ids[v + 3] = q_entry_i.nidx[v];
    end
  end

  // edge midpoint as plain corner sum
  assign kn = nxt(k_q);
  always_comb begin
    for (int i = 0; i < 3; i++) begin
      vsum[i] = $signed({pts[{1'b0, k_q}][i][15], pts[{1'b0, k_q}][i]}) +
                $signed({pts[{1'b0, kn}][i][15], pts[{1'b0, kn}][i]});
    end
  end

  // corners of the current sub-triangle
  assign p0 = pts[sts_pkg::tri_corner(k_q, 2'd0)];
  assign p1 = pts[sts_pkg::tri_corner(k_q, 2'd1)];
  assign p2 = pts[sts_pkg::tri_corner(k_q, 2'd2)];

  // one cross product term per cycle
  assign comp   = m_q[2:1];
  assign ia     = m_q[0] ? prv(comp) : nxt(comp);
  assign ib     = m_q[0] ? nxt(comp) : prv(comp);
  assign opa    = e1_q[ia];
  assign opb    = e2_q[ib];
  assign prod_d = $signed({{(WW-17){opa[16]}}, opa}) * $signed({{(WW-17){opb[16]}}, opb});
  assign pm     = m_q - 3'd1;

  // normalizer hookup
  assign start = (state_q == B_VSTART) || (state_q == B_TSTART);
  always_comb begin
    for (int i = 0; i < 3; i++) begin
      nvec[i] = (state_q == B_VSTART) ? $signed({{(WW-17){vsum[i][16]}}, vsum[i]}) : c_q[i];
    end
  end

  sts_norm u_norm (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (start),
    .vec_i   (nvec),
    .done_o  (done),
    .res_o   (nres)
  );

  assign emit_ok    = ~rec_full_i;
  assign rec_push_o = ((state_q == B_VEMIT) || (state_q == B_TEMIT)) && emit_ok;
  assign q_pop_o    = (state_q == B_TEMIT) && emit_ok && (k_q == 2'd3);

  // sequencer
  always_comb begin
    state_d = state_q;
    k_d     = k_q;
    m_d     = m_q;
    unique case (state_q)
      B_IDLE: begin
        if (!q_empty_i) begin
          state_d = B_VSTART;
          k_d     = 2'd0;
        end
      end
      B_VSTART: state_d = B_VWAIT;
      B_VWAIT: begin
        if (done) state_d = B_VEMIT;
      end
      B_VEMIT: begin
        if (emit_ok) begin
          if (k_q == 2'd2) begin
            k_d     = 2'd0;
            state_d = B_EDGE;
          end else begin
            k_d     = k_q + 2'd1;
            state_d = B_VSTART;
          end
        end
      end
      B_EDGE: begin
        state_d = B_MUL;
        m_d     = 3'd0;
      end
      B_MUL: begin
        m_d = m_q + 3'd1;
        if (m_q == 3'd6) state_d = B_TSTART;
      end
      B_TSTART: state_d = B_TWAIT;
      B_TWAIT: begin
        if (done) state_d = B_TEMIT;
      end
      B_TEMIT: begin
        if (emit_ok) begin
          if (k_q == 2'd3) begin
            state_d = B_IDLE;
          end else begin
            k_d     = k_q + 2'd1;
            state_d = B_EDGE;
          end
        end
      end
      default: state_d = B_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= B_IDLE;
      k_q     <= '0;
      m_q     <= '0;
    end else begin
      state_q <= state_d;
      k_q     <= k_d;
      m_q     <= m_d;
    end
  end

  // datapath; edge vectors stay far below the shrink limit at these widths
  always_ff @(posedge clk_i) begin
    if (state_q == B_VWAIT && done) begin
      for (int i = 0; i < 3; i++) mid_q[k_q][i] <= nres[i];
    end
    if (state_q == B_TWAIT && done) begin
      for (int i = 0; i < 3; i++) nrm_q[i] <= nres[i];
    end
    if (state_q == B_EDGE) begin
      for (int i = 0; i < 3; i++) begin
        e1_q[i] <= $signed({p1[i][15], p1[i]}) - $signed({p0[i][15], p0[i]});
        e2_q[i] <= $signed({p2[i][15], p2[i]}) - $signed({p0[i][15], p0[i]});
      end
    end
    if (state_q == B_MUL) begin
      if (m_q != 3'd6) prod_q <= prod_d;
      if (m_q != 3'd0) begin
        if (pm[0]) begin
          c_q[pm[2:1]] <= c_q[pm[2:1]] - prod_q;
        end else begin
          c_q[pm[2:1]] <= prod_q;
        end
      end
    end
  end

  // record assembly
  always_comb begin
    rec_o     = '0;
    rec_o.ovf = q_entry_i.ovf;
    if (state_q == B_TEMIT) begin
      rec_o.kind   = sts_pkg::KIND_TRI;
      rec_o.idx[0] = ids[sts_pkg::tri_corner(k_q, 2'd0)];
      rec_o.idx[1] = ids[sts_pkg::tri_corner(k_q, 2'd1)];
      rec_o.idx[2] = ids[sts_pkg::tri_corner(k_q, 2'd2)];
      rec_o.nrm    = nrm_q;
      rec_o.last   = (k_q == 2'd3);
    end else begin
      rec_o.kind   = sts_pkg::KIND_VERT;
      rec_o.pos    = mid_q[k_q];
      rec_o.idx[0] = q_entry_i.nidx[k_q];
    end
  end

endmodule

>>> rtl/core/sphere_triangle_subdivider.sv
// top level of the sphere triangle subdivider: register port, front, queues and back
// Each triangle yields seven records: three midpoint vertex records, then four sub-triangle
// records. Throughput is bounded by the shared normalizer, which makes seven passes per
// triangle, each with shrink steps, a sum of squares and the root digit loop, and by the
// record queue when it is full; the front can queue new triangles until its queue is full.
// Reset is asynchronous: vertex counter and wrap flag clear, both queues come up empty.
`timescale 1ns / 1ps

module sphere_triangle_subdivider #(
  parameter int IndexBits  = sts_pkg::INDEX_BITS_DEF,
  parameter int QueueDepth = sts_pkg::QUEUE_DEPTH_DEF,
  parameter int OutDepth   = sts_pkg::OUT_DEPTH_DEF
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [2:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready,
  input  logic        push,
  output logic        full,
  input  logic signed [15:0] a_x_i,
  input  logic signed [15:0] a_y_i,
  input  logic signed [15:0] a_z_i,
  input  logic signed [15:0] b_x_i,
  input  logic signed [15:0] b_y_i,
  input  logic signed [15:0] b_z_i,
  input  logic signed [15:0] c_x_i,
  input  logic signed [15:0] c_y_i,
  input  logic signed [15:0] c_z_i,
  input  logic [15:0] a_index_i,
  input  logic [15:0] b_index_i,
  input  logic [15:0] c_index_i,
  output logic        empty,
  input  logic        pop,
  output logic        record_kind_o,
  output logic signed [15:0] pos_x_o,
  output logic signed [15:0] pos_y_o,
  output logic signed [15:0] pos_z_o,
  output logic [15:0] index_first_o,
  output logic [15:0] index_second_o,
  output logic [15:0] index_third_o,
  output logic signed [15:0] norm_x_o,
  output logic signed [15:0] norm_y_o,
  output logic signed [15:0] norm_z_o,
  output logic        index_overflow_o,
  output logic        last_record_o
);

  logic [15:0]                       base_q;
  logic                              cfg_wr, cfg_load;
  sts_pkg::vec3_t [2:0]              in_pos;
  logic [2:0][sts_pkg::IDX_W-1:0]    in_idx;
  logic                              q_wr, q_full, q_empty, q_pop;
  sts_pkg::tri_t                     q_in, q_head;
  logic                              rec_push, rec_full;
  sts_pkg::rec_t                     rec_in, rec_out;

  // register port
  assign pready   = 1'b1;
  assign cfg_wr   = psel & penable & pwrite & pready;
  assign cfg_load = cfg_wr & (paddr[2] == sts_pkg::REG_BASE_COUNT);
  assign prdata   = (paddr[2] == sts_pkg::REG_BASE_COUNT) ? {16'd0, base_q} : 32'd0;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      base_q <= '0;
    end else if (cfg_load) begin
      base_q <= pwdata[15:0];
    end
  end

  // input payload
  always_comb begin
    in_pos[0] = {a_z_i, a_y_i, a_x_i};
    in_pos[1] = {b_z_i, b_y_i, b_x_i};
    in_pos[2] = {c_z_i, c_y_i, c_x_i};
    in_idx    = {c_index_i, b_index_i, a_index_i};
  end

  sts_front #(
    .IndexBits (IndexBits)
  ) u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_load_i  (cfg_load),
    .cfg_value_i (pwdata[15:0]),
    .push_i      (push),
    .full_i      (q_full),
    .pos_i       (in_pos),
    .idx_i       (in_idx),
    .wr_o        (q_wr),
    .entry_o     (q_in)
  );

  assign full = q_full;

  // triangle queue between front and back
  sts_fifo #(
    .Width ($bits(sts_pkg::tri_t)),
    .Depth (QueueDepth)
  ) u_tri_queue (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (q_wr),
    .data_i  (q_in),
    .full_o  (q_full),
    .pop_i   (q_pop),
    .data_o  (q_head),
    .empty_o (q_empty)
  );

  sts_back u_back (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .q_empty_i  (q_empty),
    .q_entry_i  (q_head),
    .q_pop_o    (q_pop),
    .rec_full_i (rec_full),
    .rec_push_o (rec_push),
    .rec_o      (rec_in)
  );

  // result record queue
  sts_fifo #(
    .Width ($bits(sts_pkg::rec_t)),
    .Depth (OutDepth)
  ) u_rec_queue (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (rec_push),
    .data_i  (rec_in),
    .full_o  (rec_full),
    .pop_i   (pop),
    .data_o  (rec_out),
    .empty_o (empty)
  );

  // result ports
  assign record_kind_o    = rec_out.kind;
  assign pos_x_o          = rec_out.pos[0];
  assign pos_y_o          = rec_out.pos[1];
  assign pos_z_o          = rec_out.pos[2];
  assign index_first_o    = rec_out.idx[0];
  assign index_second_o   = rec_out.idx[1];
  assign index_third_o    = rec_out.idx[2];
  assign norm_x_o         = rec_out.nrm[0];
  assign norm_y_o         = rec_out.nrm[1];
  assign norm_z_o         = rec_out.nrm[2];
  assign index_overflow_o = rec_out.ovf;
  assign last_record_o    = rec_out.last;

  // checks
  a_push_room: assert property (@(posedge clk_i) disable iff (!rst_ni)
    rec_push |-> !rec_full)
    else $error("record pushed into full queue");

  a_last_is_tri: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (!empty && last_record_o) |-> (record_kind_o == sts_pkg::KIND_TRI))
    else $error("final record is not a sub-triangle");

  a_vert_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (!empty && record_kind_o == sts_pkg::KIND_VERT) |->
      (index_second_o == '0 && index_third_o == '0 && norm_x_o == '0 &&
       norm_y_o == '0 && norm_z_o == '0))
    else $error("vertex record carries triangle fields");

  a_tri_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (!empty && record_kind_o == sts_pkg::KIND_TRI) |->
      (pos_x_o == '0 && pos_y_o == '0 && pos_z_o == '0))
    else $error("sub-triangle record carries a position");

  a_pop_on_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    q_pop |-> (rec_push && rec_in.last))
    else $error("triangle retired before its final record");

endmodule

>>> tb/sv/sphere_triangle_subdivider_tb.sv
// self-checking testbench of the sphere triangle subdivider with a predicting scoreboard
`timescale 1ns / 1ps

module sphere_triangle_subdivider_tb;

  typedef longint vec_t [3];

  // one input triangle
  typedef struct {
    logic signed [15:0] crd [9];
    logic [15:0]        vidx [3];
  } tri_item_t;

  // one output record
  typedef struct {
    logic               kind;
    logic signed [15:0] pos [3];
    logic [15:0]        idx [3];
    logic signed [15:0] nrm [3];
    logic               ovf;
    logic               last;
  } record_t;

  // predicts the records of every accepted triangle and checks them in order
  class subdiv_scoreboard;
    record_t     pending_recs[$];
    logic [15:0] vertex_counter;
    bit          wrapped;

    function new();
      vertex_counter = '0;
      wrapped        = 1'b0;
    endfunction

    function void load_base(logic [15:0] base);
      vertex_counter = base;
      wrapped        = 1'b0;
    endfunction

    // halve all magnitudes until each is below lim, keeping signs
    function void shrink_vec(ref vec_t v, input longint lim);
      longint m [3];
      bit     neg [3];
      for (int i = 0; i < 3; i++) begin
        neg[i] = v[i] < 0;
        m[i]   = neg[i] ? -v[i] : v[i];
      end
      while (m[0] >= lim || m[1] >= lim || m[2] >= lim) begin
        for (int i = 0; i < 3; i++) m[i] = m[i] >>> 1;
      end
      for (int i = 0; i < 3; i++) v[i] = neg[i] ? -m[i] : m[i];
    endfunction

    // project onto the unit sphere in Q2.14, rounding half up
    function void normalize(input vec_t vin, output vec_t vout);
      vec_t v;
      longint unsigned s, a, rhs, lo, hi, mid, t;
      v = vin;
      shrink_vec(v, 64'd65536);
      s = 0;
      for (int i = 0; i < 3; i++) begin
        a = (v[i] < 0) ? -v[i] : v[i];
        s += a * a;
      end
      for (int i = 0; i < 3; i++) begin
        a   = (v[i] < 0) ? -v[i] : v[i];
        rhs = (a * a) << 30;
        lo  = 0;
        hi  = 16384;
        if (s == 0) begin
          vout[i] = 0;
        end else begin
          while (lo < hi) begin
            mid = (lo + hi + 1) / 2;
            t   = 2 * mid - 1;
            if (t * t * s <= rhs) lo = mid;
            else hi = mid - 1;
          end
          vout[i] = (v[i] < 0) ? -longint'(lo) : longint'(lo);
        end
      end
    endfunction

    function void note_triangle(tri_item_t it);
      vec_t        pt [6];
      logic [15:0] id [6];
      vec_t        sum, e1, e2, cr, n;
      record_t     r;
      int          corner_map [4][3];
      corner_map = '{'{0, 3, 5}, '{3, 1, 4}, '{5, 4, 2}, '{3, 4, 5}};
      for (int k = 0; k < 3; k++) begin
        for (int i = 0; i < 3; i++) pt[k][i] = longint'(it.crd[k*3+i]);
        id[k] = it.vidx[k];
      end
      // edge midpoints and their new indices
      for (int k = 0; k < 3; k++) begin
        for (int i = 0; i < 3; i++) sum[i] = pt[k][i] + pt[(k+1)%3][i];
        normalize(sum, pt[3+k]);
        id[3+k] = vertex_counter;
        vertex_counter = vertex_counter + 16'd1;
        if (vertex_counter == 16'd0) wrapped = 1'b1;
      end
      for (int k = 0; k < 3; k++) begin
        r.kind = sts_pkg::KIND_VERT;
        for (int i = 0; i < 3; i++) begin
          r.pos[i] = pt[3+k][i][15:0];
          r.nrm[i] = '0;
        end
        r.idx  = '{id[3+k], 16'd0, 16'd0};
        r.ovf  = wrapped;
        r.last = 1'b0;
        pending_recs = {pending_recs, r};
      end
      // four sub-triangles with face normals
      for (int k = 0; k < 4; k++) begin
        for (int i = 0; i < 3; i++) begin
          e1[i] = pt[corner_map[k][1]][i] - pt[corner_map[k][0]][i];
          e2[i] = pt[corner_map[k][2]][i] - pt[corner_map[k][0]][i];
        end
        shrink_vec(e1, 64'd1073741824);
        shrink_vec(e2, 64'd1073741824);
        cr[0] = e1[1] * e2[2] - e1[2] * e2[1];
        cr[1] = e1[2] * e2[0] - e1[0] * e2[2];
        cr[2] = e1[0] * e2[1] - e1[1] * e2[0];
        normalize(cr, n);
        r.kind = sts_pkg::KIND_TRI;
        for (int i = 0; i < 3; i++) begin
          r.pos[i] = '0;
          r.nrm[i] = n[i][15:0];
          r.idx[i] = id[corner_map[k][i]];
        end
        r.ovf  = wrapped;
        r.last = (k == 3);
        pending_recs = {pending_recs, r};
      end
    endfunction

    // empty string when the record matches the oldest expectation
    function string check_record(record_t got);
      record_t e;
      string   msg;
      if (pending_recs.size() == 0) return "record with no expectation waiting";
      e   = pending_recs.pop_front();
      msg = "";
      if (got.kind !== e.kind)
        msg = {msg, $sformatf(" kind %0d/%0d", got.kind, e.kind)};
      for (int i = 0; i < 3; i++) begin
        if (got.pos[i] !== e.pos[i])
          msg = {msg, $sformatf(" pos[%0d] %0d/%0d", i, got.pos[i], e.pos[i])};
        if (got.idx[i] !== e.idx[i])
          msg = {msg, $sformatf(" idx[%0d] %0d/%0d", i, got.idx[i], e.idx[i])};
        if (got.nrm[i] !== e.nrm[i])
          msg = {msg, $sformatf(" nrm[%0d] %0d/%0d", i, got.nrm[i], e.nrm[i])};
      end
      if (got.ovf !== e.ovf)
        msg = {msg, $sformatf(" overflow %0d/%0d", got.ovf, e.ovf)};
      if (got.last !== e.last)
        msg = {msg, $sformatf(" last %0d/%0d", got.last, e.last)};
      return msg;
    endfunction
  endclass

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic psel = 1'b0, penable = 1'b0, pwrite = 1'b0;
  logic [2:0]  paddr = '0;
  logic [31:0] pwdata = '0;
  logic [31:0] prdata;
  logic pready;
  logic push = 1'b0, full;
  logic signed [15:0] crd_in [9];
  logic [15:0] vidx_in [3];
  logic empty, pop = 1'b0;
  logic record_kind_o, index_overflow_o, last_record_o;
  logic signed [15:0] pos_x_o, pos_y_o, pos_z_o, norm_x_o, norm_y_o, norm_z_o;
  logic [15:0] index_first_o, index_second_o, index_third_o;

  subdiv_scoreboard sb = new();
  int  mismatches = 0;
  bit  calm = 1'b0;

  initial begin
    for (int i = 0; i < 9; i++) crd_in[i] = '0;
    for (int i = 0; i < 3; i++) vidx_in[i] = '0;
  end

  sphere_triangle_subdivider DUT (
    .clk_i, .rst_ni, .psel, .penable, .pwrite, .paddr, .pwdata, .prdata, .pready,
    .push, .full,
    .a_x_i(crd_in[0]), .a_y_i(crd_in[1]), .a_z_i(crd_in[2]),
    .b_x_i(crd_in[3]), .b_y_i(crd_in[4]), .b_z_i(crd_in[5]),
    .c_x_i(crd_in[6]), .c_y_i(crd_in[7]), .c_z_i(crd_in[8]),
    .a_index_i(vidx_in[0]), .b_index_i(vidx_in[1]), .c_index_i(vidx_in[2]),
    .empty, .pop, .record_kind_o, .pos_x_o, .pos_y_o, .pos_z_o,
    .index_first_o, .index_second_o, .index_third_o,
    .norm_x_o, .norm_y_o, .norm_z_o, .index_overflow_o, .last_record_o
  );

  // clock
  always begin
    #6 clk_i = 1'b1;
    #6 clk_i = 1'b0;
  end

  task automatic report(string msg);
    mismatches++;
    $display("mismatch at %0t:%s", $realtime, msg);
  endtask

  // register write in setup and access phases
  task automatic reg_write(logic [2:0] addr, logic [31:0] data);
    @(negedge clk_i);
    psel = 1'b1; penable = 1'b0; pwrite = 1'b1; paddr = addr; pwdata = data;
    @(negedge clk_i);
    penable = 1'b1;
    do @(posedge clk_i); while (!pready);
    if (addr[2] == sts_pkg::REG_BASE_COUNT) sb.load_base(data[15:0]);
    @(negedge clk_i);
    psel = 1'b0; penable = 1'b0; pwrite = 1'b0;
  endtask

  task automatic wait_drained();
    while (sb.pending_recs.size() != 0) @(negedge clk_i);
    repeat (300) @(negedge clk_i);
  endtask

  // one input transaction, with an optional idle burst after it
  task automatic send_triangle(tri_item_t it);
    crd_in  = it.crd;
    vidx_in = it.vidx;
    push    = 1'b1;
    do @(posedge clk_i); while (full);
    sb.note_triangle(it);
    @(negedge clk_i);
    if (!calm && $urandom_range(0, 3) == 0) begin
      push = 1'b0;
      repeat ($urandom_range(1, 17)) @(negedge clk_i);
    end
  endtask

  task automatic send_triangle_idle(tri_item_t it);
    send_triangle(it);
    push = 1'b0;
  endtask

  function automatic tri_item_t make_tri(int c0, int c1, int c2, int c3, int c4, int c5,
                                         int c6, int c7, int c8, int i0, int i1, int i2);
    tri_item_t it;
    it.crd  = '{c0[15:0], c1[15:0], c2[15:0], c3[15:0], c4[15:0], c5[15:0],
                c6[15:0], c7[15:0], c8[15:0]};
    it.vidx = '{i0[15:0], i1[15:0], i2[15:0]};
    return it;
  endfunction

  // mostly points near the sphere, sometimes fully random or degenerate
  function automatic tri_item_t rand_tri();
    tri_item_t it;
    int mode;
    mode = $urandom_range(0, 9);
    for (int i = 0; i < 9; i++) begin
      if (mode < 6) it.crd[i] = $signed(16'($urandom_range(0, 32768))) - 16'sd16384;
      else it.crd[i] = 16'($urandom);
    end
    if (mode == 9) begin
      for (int i = 0; i < 3; i++) it.crd[3+i] = it.crd[i];
    end else if (mode == 8) begin
      for (int i = 0; i < 3; i++) it.crd[6+i] = -it.crd[i];
    end
    for (int i = 0; i < 3; i++) it.vidx[i] = 16'($urandom);
    return it;
  endfunction

  task automatic random_phase(int n);
    for (int k = 0; k < n; k++) send_triangle(rand_tri());
    push = 1'b0;
  endtask

  // result side with random stall bursts
  initial begin
    record_t got;
    string   msg;
    forever begin
      @(negedge clk_i);
      if (!calm && $urandom_range(0, 5) == 0) begin
        pop = 1'b0;
        repeat ($urandom_range(1, 17)) @(negedge clk_i);
      end
      pop = 1'b1;
      @(posedge clk_i);
      if (pop && !empty) begin
        got.kind = record_kind_o;
        got.pos  = '{pos_x_o, pos_y_o, pos_z_o};
        got.idx  = '{index_first_o, index_second_o, index_third_o};
        got.nrm  = '{norm_x_o, norm_y_o, norm_z_o};
        got.ovf  = index_overflow_o;
        got.last = last_record_o;
        msg = sb.check_record(got);
        if (msg != "") report(msg);
      end
    end
  end

  // stimulus
  initial begin
    repeat (12) @(negedge clk_i);
    rst_ni = 1'b1;
    repeat (3) @(negedge clk_i);

    // write to an unmapped address leaves the counter alone
    reg_write(3'd4, 32'h0000_1234);

    // directed corners: extremes, zero vectors, degenerate and opposite points
    send_triangle_idle(make_tri(16384, 0, 0, 0, 16384, 0, 0, 0, 16384, 0, 1, 2));
    send_triangle_idle(make_tri(-32768, -32768, -32768, -32768, -32768, -32768,
                                -32768, -32768, -32768, 65535, 65535, 65535));
    send_triangle_idle(make_tri(32767, 32767, 32767, 32767, 32767, 32767,
                                32767, 32767, 32767, 0, 0, 0));
    send_triangle_idle(make_tri(32767, -32768, 32767, -32768, 32767, -32768,
                                32767, 32767, -32768, 65535, 0, 65535));
    send_triangle_idle(make_tri(0, 0, 0, 0, 0, 0, 0, 0, 0, 7, 8, 9));
    send_triangle_idle(make_tri(100, -200, 300, 100, -200, 300, -50, 70, 10, 1, 1, 2));
    send_triangle_idle(make_tri(16384, 0, 0, -16384, 0, 0, 0, 0, 16384, 3, 4, 5));
    send_triangle_idle(make_tri(1000, 1000, 1000, 2000, 2000, 2000, 3000, 3000, 3000,
                                10, 11, 12));
    send_triangle_idle(make_tri(1, 0, 0, 0, 1, 0, 0, 0, 1, 21845, 43690, 65535));
    send_triangle_idle(make_tri(-1, -1, -1, 1, 1, 1, -1, 1, -1, 0, 0, 0));
    send_triangle_idle(make_tri(-16384, -16384, 0, 0, -16384, -16384, -16384, 0, -16384,
                                100, 200, 300));
    send_triangle_idle(make_tri(32767, 0, 0, 0, 32767, 0, 0, 0, 32767, 5, 6, 7));
    wait_drained();

    // counter wraps inside the first triangle
    reg_write(3'd0, 32'hFFFF_FFFE);
    send_triangle_idle(make_tri(16384, 0, 0, 0, 16384, 0, 0, 0, 16384, 1, 2, 3));
    random_phase(40);

    // hold off the sender until everything has come out
    wait_drained();
    reg_write(3'd0, 32'h0000_FFFF);
    random_phase(40);
    wait_drained();

    reg_write(3'd0, 32'd0);
    random_phase(40);
    wait_drained();

    reg_write(3'd0, 32'($urandom_range(0, 65535)));
    random_phase(20);
    calm = 1'b1;
    random_phase(30);

    while (sb.pending_recs.size() != 0) @(negedge clk_i);
    repeat (300) @(negedge clk_i);
    if (mismatches == 0 && sb.pending_recs.size() == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

  // run time limit
  initial begin
    #20ms;
    $display("simulation failed");
    $finish;
  end

endmodule

>>> filelist.f
rtl/core/sts_pkg.sv
rtl/core/sts_fifo.sv
rtl/core/sts_front.sv
rtl/core/sts_norm.sv
rtl/core/sts_back.sv
rtl/core/sphere_triangle_subdivider.sv
tb/sv/sphere_triangle_subdivider_tb.sv
